### hw/rtl/kth_largest_min_heap_tracker_core_defines.svh
// assertion macros for the k-th largest tracker checker
`ifndef KTH_LARGEST_MIN_HEAP_TRACKER_CORE_DEFINES_SVH
`define KTH_LARGEST_MIN_HEAP_TRACKER_CORE_DEFINES_SVH

// same-cycle implication, disabled during reset
`define KLH_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("klh assertion failed");

// next-cycle implication, disabled during reset
`define KLH_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("klh assertion failed");

`endif

### hw/rtl/klh_pkg.sv
// shared constants and types of the k-th largest tracker
`timescale 1ns / 1ps
package klh_pkg;

  localparam int K_MAX_DEF       = 64;
  localparam int VALUE_WIDTH_DEF = 16;
  localparam int KCNT_W          = 7;
  localparam logic [KCNT_W-1:0] K_RESET = KCNT_W'(1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UP_RD,
    ST_UP_CMP,
    ST_DN_RDL,
    ST_DN_RDR,
    ST_DN_CMP,
    ST_WR_V,
    ST_RESULT
  } state_e;

endpackage

### hw/rtl/kth_largest_min_heap_tracker_core.sv
// top level of the k-th largest tracker: min-heap in ram with sift sequencer
//
//   channel  direction  handshake               payload
//   cfg      in         cfg_we_i                cfg_wdata_i (k)
//   in       in         in_valid_i/in_ready_o   value_i
//   out      out        out_valid_o/out_ready_i kth_largest_o, ready_res_o
//
// an item is taken only in the idle state and the heap is walked one level at a time
// value below or equal to the root of a full heap: dropped, straight to the result state
// insertion: each parent compared takes a ram read, then a compare and write back
// replacement: left read, right read, then compare and write back per level; a leaf ends it
// reset empties the heap at once; a stalled result holds the sequencer in its result state
`timescale 1ns / 1ps
module kth_largest_min_heap_tracker_core #(
  parameter int K_MAX       = klh_pkg::K_MAX_DEF,
  parameter int VALUE_WIDTH = klh_pkg::VALUE_WIDTH_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [klh_pkg::KCNT_W-1:0] cfg_wdata_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [VALUE_WIDTH-1:0]    value_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [VALUE_WIDTH-1:0]    kth_largest_o,
  output logic                      ready_res_o
);

  localparam int AW = (K_MAX > 1) ? $clog2(K_MAX) : 1;
  localparam int FW = $clog2(K_MAX + 1);
  localparam int XW = AW + 2;

  klh_pkg::state_e state_q, state_d;

  logic [klh_pkg::KCNT_W-1:0] k_q;
  logic [FW-1:0]              fill_q;
  logic [AW-1:0]              pos_q;
  logic [VALUE_WIDTH-1:0]     val_q;
  logic [VALUE_WIDTH-1:0]     lval_q;
  logic [VALUE_WIDTH-1:0]     root_q;
  logic                       out_valid_q;
  logic [VALUE_WIDTH-1:0]     out_kth_q;
  logic                       out_rdy_q;

  logic [FW-1:0]          keff;
  logic [XW-1:0]          left_x, right_x, keff_x;
  logic                   left_ok, right_ok;
  logic [AW-1:0]          left_a, right_a, parent_a, fill_a;
  logic                   accept, fill_lt, v_gt_root, up_less;
  logic                   take_l, take_r, out_free, ready_now;
  logic [VALUE_WIDTH-1:0] best;

  logic                   ram_we;
  logic [AW-1:0]          ram_waddr, ram_raddr;
  logic [VALUE_WIDTH-1:0] ram_wdata, ram_rdata;

  // effective rank, clamped to 1..K_MAX
  always_comb begin
    if (k_q == '0) begin
      keff = FW'(1);
    end else if (32'(k_q) > 32'(K_MAX)) begin
      keff = FW'(K_MAX);
    end else begin
      keff = FW'(k_q);
    end
  end

  assign left_x   = {1'b0, pos_q, 1'b1};
  assign right_x  = left_x + XW'(1);
  assign keff_x   = XW'(keff);
  assign left_ok  = left_x < keff_x;
  assign right_ok = right_x < keff_x;
  assign left_a   = left_x[AW-1:0];
  assign right_a  = right_x[AW-1:0];
  assign parent_a = (pos_q - AW'(1)) >> 1;
  assign fill_a   = fill_q[AW-1:0];

  assign in_ready_o = (state_q == klh_pkg::ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign fill_lt    = fill_q < keff;
  assign ready_now  = fill_q >= keff;
  assign v_gt_root  = $signed(value_i) > $signed(root_q);
  assign up_less    = $signed(val_q) < $signed(ram_rdata);
  assign take_l     = $signed(lval_q) < $signed(val_q);
  assign best       = take_l ? lval_q : val_q;
  assign take_r     = right_ok && ($signed(ram_rdata) < $signed(best));
  assign out_free   = !out_valid_q || out_ready_i;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      klh_pkg::ST_IDLE: begin
        if (accept) begin
          priority if (fill_lt) begin
            state_d = (fill_q == '0) ? klh_pkg::ST_WR_V : klh_pkg::ST_UP_RD;
          end else if (v_gt_root) begin
            state_d = klh_pkg::ST_DN_RDL;
          end else begin
            state_d = klh_pkg::ST_RESULT;
          end
        end
      end
      klh_pkg::ST_UP_RD: state_d = klh_pkg::ST_UP_CMP;
      klh_pkg::ST_UP_CMP: begin
        if (up_less && (parent_a != '0)) begin
          state_d = klh_pkg::ST_UP_RD;
        end else begin
          state_d = klh_pkg::ST_WR_V;
        end
      end
      klh_pkg::ST_DN_RDL: state_d = left_ok ? klh_pkg::ST_DN_RDR : klh_pkg::ST_WR_V;
      klh_pkg::ST_DN_RDR: state_d = klh_pkg::ST_DN_CMP;
      klh_pkg::ST_DN_CMP: begin
        state_d = (take_l || take_r) ? klh_pkg::ST_DN_RDL : klh_pkg::ST_WR_V;
      end
      klh_pkg::ST_WR_V:   state_d = klh_pkg::ST_RESULT;
      klh_pkg::ST_RESULT: state_d = out_free ? klh_pkg::ST_IDLE : klh_pkg::ST_RESULT;
      default:            state_d = klh_pkg::ST_IDLE;
    endcase
  end

  // ram controls
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = pos_q;
    ram_wdata = val_q;
    ram_raddr = '0;
    unique case (state_q)
      klh_pkg::ST_UP_RD:  ram_raddr = parent_a;
      klh_pkg::ST_UP_CMP: begin
        if (up_less) begin
          ram_we    = 1'b1;
          ram_wdata = ram_rdata;
        end
      end
      klh_pkg::ST_DN_RDL: ram_raddr = left_a;
      klh_pkg::ST_DN_RDR: ram_raddr = right_a;
      klh_pkg::ST_DN_CMP: begin
        if (take_l || take_r) begin
          ram_we    = 1'b1;
          ram_wdata = take_r ? ram_rdata : lval_q;
        end
      end
      klh_pkg::ST_WR_V:   ram_we = 1'b1;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= klh_pkg::ST_IDLE;
      k_q         <= klh_pkg::K_RESET;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        k_q    <= cfg_wdata_i;
        fill_q <= '0;
      end else if (accept && fill_lt) begin
        fill_q <= fill_q + FW'(1);
      end
      if ((state_q == klh_pkg::ST_RESULT) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      val_q <= value_i;
      pos_q <= fill_lt ? fill_a : '0;
    end
    if ((state_q == klh_pkg::ST_UP_CMP) && up_less) begin
      pos_q <= parent_a;
    end
    if (state_q == klh_pkg::ST_DN_RDR) begin
      lval_q <= ram_rdata;
    end
    if ((state_q == klh_pkg::ST_DN_CMP) && (take_l || take_r)) begin
      pos_q <= take_r ? right_a : left_a;
    end
    // shadow copy of the heap root
    if (ram_we && (ram_waddr == '0)) begin
      root_q <= ram_wdata;
    end
    if ((state_q == klh_pkg::ST_RESULT) && out_free) begin
      out_kth_q <= ready_now ? root_q : '0;
      out_rdy_q <= ready_now;
    end
  end

  klh_ram #(
    .WIDTH(VALUE_WIDTH),
    .DEPTH(K_MAX)
  ) u_heap_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign out_valid_o   = out_valid_q;
  assign kth_largest_o = out_kth_q;
  assign ready_res_o   = out_rdy_q;

endmodule

### hw/rtl/klh_ram.sv
// generic single-port-write ram with registered read
`timescale 1ns / 1ps
module klh_ram #(
  parameter int WIDTH = klh_pkg::VALUE_WIDTH_DEF,
  parameter int DEPTH = klh_pkg::K_MAX_DEF,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### hw/rtl/klh_chk.sv
// port-level checker for the k-th largest tracker, bound to the top level
`timescale 1ns / 1ps
`include "kth_largest_min_heap_tracker_core_defines.svh"
module klh_chk #(
  parameter int VALUE_WIDTH = klh_pkg::VALUE_WIDTH_DEF
) (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_ready_o,
  input logic                       out_valid_o,
  input logic                       out_ready_i,
  input logic [VALUE_WIDTH-1:0]     kth_largest_o,
  input logic                       ready_res_o
);

  `KLH_ASSERT_NEXT(a_valid_hold, out_valid_o && !out_ready_i, out_valid_o)
  `KLH_ASSERT_NEXT(a_data_hold, out_valid_o && !out_ready_i, $stable({kth_largest_o, ready_res_o}))
  `KLH_ASSERT_NOW(a_zero_not_ready, out_valid_o && !ready_res_o, kth_largest_o == '0)
  `KLH_ASSERT_NEXT(a_busy_after_item, in_valid_i && in_ready_o, !in_ready_o)
  `KLH_ASSERT_NEXT(a_result_after_item, in_valid_i && in_ready_o && !out_valid_o, !out_valid_o)

endmodule

bind kth_largest_min_heap_tracker_core klh_chk #(
  .VALUE_WIDTH(VALUE_WIDTH)
) u_klh_chk (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_ready_o   (in_ready_o),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .kth_largest_o(kth_largest_o),
  .ready_res_o  (ready_res_o)
);
